// ===== rtl/hafir_pkg.sv =====
package hafir_pkg;

  localparam int MAX_LINE_WIDTH = 4096;
  localparam int COL_W = $clog2(MAX_LINE_WIDTH);
  localparam int LW_W = 13;
  localparam int CH_W = 8;
  localparam int NTAPS = 5;
  localparam int NWIN = NTAPS - 1;
  localparam int NLANES = 3;
  localparam int COEF_W = 4;
  localparam int ACC_W = 11;
  localparam int KSHIFT = 3;
  localparam int MAX_RES = 3;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [COEF_W-1:0] KERNELS [0:3][0:NTAPS-1] = '{
    '{4'd0, 4'd0, 4'd8, 4'd0, 4'd0},
    '{4'd0, 4'd1, 4'd6, 4'd1, 4'd0},
    '{4'd0, 4'd2, 4'd4, 4'd2, 4'd0},
    '{4'd1, 4'd2, 4'd2, 4'd2, 4'd1}
  };

  // lane 2 red, lane 1 green, lane 0 blue
  typedef logic [CH_W-1:0] chan_t;
  typedef chan_t [NLANES-1:0] pix_t;

  typedef struct packed {
    pix_t pix;
    logic line_end;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    logic last;
    res_t [MAX_RES-1:0] ent;
  } push_t;

endpackage

// ===== rtl/hafir_if.sv =====
interface hafir_in_if;
  logic valid;
  logic ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source(output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink(input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface hafir_out_if;
  logic valid;
  logic ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic line_end;

  modport source(output valid, output red_out, output green_out, output blue_out,
                 output line_end, input ready);
  modport sink(input valid, input red_out, input green_out, input blue_out,
               input line_end, output ready);
endinterface

// ===== rtl/hafir_lane.sv =====
module hafir_lane (
  input  logic [1:0]                                  filter_sel,
  input  hafir_pkg::chan_t [hafir_pkg::NTAPS-1:0]     taps,
  output hafir_pkg::chan_t                            filt
);
  import hafir_pkg::*;

  logic [ACC_W-1:0] acc;

  always_comb begin
    acc = '0;
    for (int i = 0; i < NTAPS; i++) begin
      acc = acc + ACC_W'(KERNELS[filter_sel][i]) * ACC_W'(taps[i]);
    end
  end

  assign filt = acc[ACC_W-1:KSHIFT];

endmodule

// ===== rtl/hafir_merge.sv =====
module hafir_merge (
  input  logic [hafir_pkg::COL_W-1:0]              col,
  input  logic [hafir_pkg::LW_W-1:0]               width,
  input  hafir_pkg::pix_t [hafir_pkg::NWIN-1:0]    win,
  input  hafir_pkg::pix_t                          px,
  input  hafir_pkg::pix_t                          filt,
  output hafir_pkg::push_t                         push
);
  import hafir_pkg::*;

  logic [LW_W-1:0] col_ext;
  logic            last;
  logic            use_filt;
  res_t            cand [MAX_RES];
  logic            cand_v [MAX_RES];
  logic [1:0]      n;

  assign col_ext  = LW_W'(col);
  assign last     = (col_ext + LW_W'(1)) >= width;
  assign use_filt = (col >= COL_W'(4)) && (col_ext < width);

  always_comb begin
    cand[0]   = '{pix: (use_filt ? filt : win[2]), line_end: 1'b0};
    cand_v[0] = col >= COL_W'(2);
    cand[1]   = '{pix: win[3], line_end: 1'b0};
    cand_v[1] = last && (col >= COL_W'(1));
    cand[2]   = '{pix: px, line_end: 1'b1};
    cand_v[2] = last;
  end

  // pack the present results in order
  always_comb begin
    push = '0;
    n = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      if (cand_v[i]) begin
        push.ent[n] = cand[i];
        n = n + 2'd1;
      end
    end
    push.n = n;
    push.last = last;
  end

endmodule

// ===== rtl/hafir_outq.sv =====
module hafir_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_en,
  input  hafir_pkg::push_t  push,
  input  logic              pop,
  output logic              room,
  output logic              head_valid,
  output hafir_pkg::res_t   head
);
  import hafir_pkg::*;

  res_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic [QCNT_W-1:0] push_n;

  assign push_n     = push_en ? QCNT_W'(push.n) : '0;
  assign room       = count_r <= QCNT_W'(QDEPTH - MAX_RES);
  assign head_valid = count_r != '0;
  assign head       = q_r[rd_ptr_r];

  assign wr_ptr_nxt = wr_ptr_r + QPTR_W'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
  assign count_nxt  = count_r + push_n - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push_en) begin
      for (int k = 0; k < MAX_RES; k++) begin
        if (2'(k) < push.n) begin
          q_r[wr_ptr_r + QPTR_W'(k)] <= push.ent[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> rd_ptr_r == wr_ptr_r)
    else $error("empty queue with unequal pointers");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty queue");

endmodule

// ===== rtl/horizontal_antialias_fir_core.sv =====
// channel  | dir | handshake            | payload
// in_ch    | in  | valid/ready          | red_in, green_in, blue_in
// out_ch   | out | valid/ready          | red_out, green_out, blue_out, line_end
// cfg_*    | in  | apb, pready always 1 | 0x0 filter_select, 0x4 line_width
//
// one pixel accepted per cycle while the queue has room; three color lanes
// filter it in the accept cycle; results go into a four-entry output queue
// an item is taken while the queue holds at most one result, so a line end
// (up to three results) can stall the input; out_ch stalls back up through
// the queue only; rst_n is synchronous and resets window, column, queue, config
// the user must write config only while idle; the block does not enforce it
module horizontal_antialias_fir_core (
  input  logic        clk,
  input  logic        rst_n,
  hafir_in_if.sink    in_ch,
  hafir_out_if.source out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import hafir_pkg::*;

  localparam logic REG_FILTER_SEL = 1'b0;
  localparam logic REG_LINE_WIDTH = 1'b1;

  logic [1:0]       filter_sel_r;
  logic [LW_W-1:0]  line_width_r;
  logic [COL_W-1:0] col_r, col_nxt;
  pix_t             win_r [NWIN];
  pix_t [NWIN-1:0]  win_pk;
  pix_t             px;
  pix_t             filt;
  logic [LW_W-1:0]  width_eff;
  logic             in_acc;
  logic             cfg_wr;
  logic             room;
  logic             head_valid;
  res_t             head;
  push_t            push;

  assign px     = {in_ch.red_in, in_ch.green_in, in_ch.blue_in};
  assign in_acc = in_ch.valid && room;
  assign in_ch.ready = room;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_paddr[2])
      REG_FILTER_SEL: cfg_prdata = 32'(filter_sel_r);
      REG_LINE_WIDTH: cfg_prdata = 32'(line_width_r);
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_sel_r <= '0;
      line_width_r <= LW_W'(640);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_FILTER_SEL: filter_sel_r <= cfg_pwdata[1:0];
        REG_LINE_WIDTH: line_width_r <= cfg_pwdata[LW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (line_width_r == '0) begin
      width_eff = LW_W'(1);
    end else if (line_width_r > LW_W'(MAX_LINE_WIDTH)) begin
      width_eff = LW_W'(MAX_LINE_WIDTH);
    end else begin
      width_eff = line_width_r;
    end
  end

  // color lanes
  for (genvar l = 0; l < NLANES; l++) begin : g_lane
    chan_t [NTAPS-1:0] taps;
    always_comb begin
      for (int t = 0; t < NWIN; t++) begin
        taps[t] = win_r[t][l];
      end
      taps[NTAPS-1] = px[l];
    end
    hafir_lane u_lane (
      .filter_sel (filter_sel_r),
      .taps       (taps),
      .filt       (filt[l])
    );
  end

  always_comb begin
    for (int t = 0; t < NWIN; t++) begin
      win_pk[t] = win_r[t];
    end
  end

  hafir_merge u_merge (
    .col   (col_r),
    .width (width_eff),
    .win   (win_pk),
    .px    (px),
    .filt  (filt),
    .push  (push)
  );

  assign col_nxt = push.last ? '0 : col_r + COL_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      for (int t = 0; t < NWIN; t++) begin
        win_r[t] <= '0;
      end
    end else if (in_acc) begin
      col_r <= col_nxt;
      for (int t = 0; t < NWIN - 1; t++) begin
        win_r[t] <= win_r[t+1];
      end
      win_r[NWIN-1] <= px;
    end
  end

  hafir_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_en    (in_acc),
    .push       (push),
    .pop        (head_valid && out_ch.ready),
    .room       (room),
    .head_valid (head_valid),
    .head       (head)
  );

  assign out_ch.valid     = head_valid;
  assign out_ch.red_out   = head.pix[2];
  assign out_ch.green_out = head.pix[1];
  assign out_ch.blue_out  = head.pix[0];
  assign out_ch.line_end  = head.line_end;

  a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && push.last |=> col_r == '0)
    else $error("column not cleared at line end");

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !push.last |=> col_r == COL_W'($past(col_r) + COL_W'(1)))
    else $error("column did not advance");

  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    push.last |-> push.n != 2'd0 && push.ent[push.n - 2'd1].line_end)
    else $error("line end item missing its final result");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import hafir_pkg::*;

  localparam int RANDOM_ITEMS = 125;
  localparam int LONG_HOLD = 80;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_PRINTED = 50;

  localparam int FIR_TAPS [4][5] = '{
    '{0, 0, 8, 0, 0},
    '{0, 1, 6, 1, 0},
    '{0, 2, 4, 2, 0},
    '{1, 2, 2, 2, 1}
  };

  typedef enum logic [2:0] {
    REG_FILTER_SELECT = 3'd0,
    REG_LINE_WIDTH    = 3'd4
  } cfg_addr_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  hafir_in_if  in_ch();
  hafir_out_if out_ch();

  horizontal_antialias_fir_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // filter state mirrored from the block
  pix_t        prev_px [4];
  int          column;
  logic [1:0]  kernel_sel;
  logic [12:0] width_reg;

  res_t expected_px_q [$];
  res_t want;
  int   err_count = 0;
  int   items_sent = 0;
  int   src_idle_pct = 26;
  int   snk_idle_pct = 53;
  int   hold_reqs = 0;

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_PRINTED)
      $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic filter_pixel(input pix_t px);
    int   w;
    int   c;
    int   acc;
    int   l;
    int   k;
    logic last;
    pix_t val;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : width_reg);
    c = column;
    last = (c + 1 >= w);
    if (c >= 2) begin
      if (c >= 4 && c < w) begin
        for (l = 0; l < NLANES; l++) begin
          acc = FIR_TAPS[kernel_sel][4] * px[l];
          for (k = 0; k < 4; k++)
            acc += FIR_TAPS[kernel_sel][k] * prev_px[k][l];
          val[l] = CH_W'(acc >> 3);
        end
      end else begin
        val = prev_px[2];
      end
      expected_px_q.push_back('{pix: val, line_end: 1'b0});
    end
    if (last) begin
      if (c >= 1)
        expected_px_q.push_back('{pix: prev_px[3], line_end: 1'b0});
      expected_px_q.push_back('{pix: px, line_end: 1'b1});
      column = 0;
    end else begin
      column = c + 1;
    end
    for (k = 0; k < 3; k++)
      prev_px[k] = prev_px[k + 1];
    prev_px[3] = px;
  endtask

  function automatic pix_t rand_pixel();
    pix_t p;
    int   l;
    for (l = 0; l < NLANES; l++) begin
      case ($urandom_range(9))
        0: p[l] = 8'h00;
        1: p[l] = 8'hFF;
        default: p[l] = CH_W'($urandom_range(255));
      endcase
    end
    return p;
  endfunction

  function automatic int pick_width();
    case ($urandom_range(19))
      0: return 0;
      1, 2, 3: return $urandom_range(13, 24);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the accept
  task automatic send_pixel(input pix_t px);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      {in_ch.red_in, in_ch.green_in, in_ch.blue_in} = rand_pixel();
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.red_in = px[2];
    in_ch.green_in = px[1];
    in_ch.blue_in = px[0];
    @(posedge clk);
    while (!in_ch.ready)
      @(posedge clk);
    filter_pixel(px);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_pixels(input pix_t list [$]);
    foreach (list[i])
      send_pixel(list[i]);
  endtask

  task automatic pause_for_results();
    in_ch.valid = 1'b0;
    while (expected_px_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_addr_e addr, input logic [31:0] data);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = addr;
    cfg_pwdata = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready)
      @(posedge clk);
    case (addr)
      REG_FILTER_SELECT: kernel_sel = data[1:0];
      REG_LINE_WIDTH: width_reg = data[12:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic reconfigure(input logic [1:0] fs, input logic [12:0] lw);
    pause_for_results();
    cfg_write(REG_FILTER_SELECT, {30'd0, fs});
    cfg_write(REG_LINE_WIDTH, {19'd0, lw});
  endtask

  task automatic test_kernel_extremes();
    reconfigure(2'd3, 13'd5);
    send_pixels('{24'hFF0080, 24'h00FF01, 24'hFFFFFE, 24'h00007F, 24'hFF80FF});
  endtask

  task automatic test_short_lines();
    reconfigure(2'd0, 13'd0);
    send_pixel(24'hA5_5A_C3);
    reconfigure(2'd0, 13'd1);
    send_pixel(24'h3C_C3_00);
    reconfigure(2'd1, 13'd3);
    send_pixels('{24'h010203, 24'hFEFDFC, 24'h808080});
    reconfigure(2'd2, 13'd4);
    send_pixels('{24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000});
  endtask

  // an oversized width and the maximum width, then a width shrink that ends the line early
  task automatic test_width_extremes();
    reconfigure(2'd1, 13'd8191);
    send_pixels('{24'h102030, 24'hF0E0D0, 24'h55AA55});
    reconfigure(2'd1, 13'd4096);
    send_pixels('{24'hAA55AA, 24'hFFFF00, 24'h00FFFF});
    reconfigure(2'd3, 13'd2);
    send_pixel(24'h7F807F);
  endtask

  task automatic test_backpressure();
    reconfigure(2'd2, 13'd24);
    hold_reqs++;
    repeat (24) send_pixel(rand_pixel());
    pause_for_results();
  endtask

  task automatic test_random_lines();
    int start;
    int done;
    start = items_sent;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      if (done >= 2 * RANDOM_ITEMS / 3) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end else if (done >= RANDOM_ITEMS / 3) begin
        src_idle_pct = 53;
        snk_idle_pct = 26;
      end
      case ($urandom_range(5))
        0: begin
          // width rewritten in the middle of a line
          reconfigure(2'($urandom_range(3)), 13'($urandom_range(5, 8191)));
          repeat ($urandom_range(1, 4)) send_pixel(rand_pixel());
          reconfigure(kernel_sel, 13'($urandom_range(0, 16)));
        end
        1, 2: reconfigure(2'($urandom_range(3)), 13'(pick_width()));
        default: ;
      endcase
      do
        send_pixel(rand_pixel());
      while (column != 0);
      done = items_sent - start;
    end
  endtask

  // result sink with random stalls and one long hold-off on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_px_q.size() == 0) begin
        report_mismatch("result with no pixel pending");
      end else begin
        want = expected_px_q.pop_front();
        if (out_ch.red_out !== want.pix[2])
          report_mismatch($sformatf("red_out %0h, want %0h", out_ch.red_out, want.pix[2]));
        if (out_ch.green_out !== want.pix[1])
          report_mismatch($sformatf("green_out %0h, want %0h", out_ch.green_out, want.pix[1]));
        if (out_ch.blue_out !== want.pix[0])
          report_mismatch($sformatf("blue_out %0h, want %0h", out_ch.blue_out, want.pix[0]));
        if (out_ch.line_end !== want.line_end)
          report_mismatch($sformatf("line_end %0b, want %0b", out_ch.line_end, want.line_end));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.red_in = '0;
    in_ch.green_in = '0;
    in_ch.blue_in = '0;
    foreach (prev_px[i])
      prev_px[i] = '0;
    column = 0;
    kernel_sel = 2'd0;
    width_reg = 13'd640;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_kernel_extremes();
    test_short_lines();
    test_width_extremes();
    test_backpressure();
    test_random_lines();

    pause_for_results();
    repeat (10) @(negedge clk);
    if (err_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
